// ===== rtl/core/led_matrix_modulation_driver_assert.svh =====
// assertion macros for the led matrix modulation driver checks
// each macro takes a label, the clock, the active-low reset and the property terms
`ifndef LED_MATRIX_MODULATION_DRIVER_ASSERT_SVH
`define LED_MATRIX_MODULATION_DRIVER_ASSERT_SVH

// same-cycle implication
`define BAM_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
		else $error("bam check failed: same-cycle implication");

// next-cycle implication
`define BAM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
		else $error("bam check failed: next-cycle implication");

`endif

// ===== rtl/core/bam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_pkg
// shared types and constants of the led matrix modulation driver
// ----------------------------------------------------------------------------
package bam_pkg;

	localparam int unsigned NumTables   = 2;
	localparam int unsigned TableDepth  = 8;
	localparam int unsigned TapBit      = 3;
	localparam logic [3:0]  StepReset   = 4'd4;

	localparam logic CmdPixel    = 1'b0;
	localparam logic CmdFrameEnd = 1'b1;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] idx_t;
	typedef logic [3:0] step_t;
	typedef logic [31:0] count_t;
	typedef byte_t table_t [TableDepth];

	// reset contents of the two modulation tables
	localparam byte_t TableInit [NumTables][TableDepth] = '{
		'{8'h00, 8'h80, 8'h88, 8'h91, 8'hA4, 8'hAA, 8'hEE, 8'hFF},
		'{8'h00, 8'h80, 8'h88, 8'h24, 8'hA4, 8'hAA, 8'hEE, 8'hFF}
	};

	typedef struct packed {
		logic  command;
		byte_t pixel_color;
	} in_item_t;

	typedef struct packed {
		logic   blue_bit;
		logic   green_bit;
		logic   red_bit;
		logic   latch_pulse;
		count_t frame_number;
	} out_item_t;

	// update strobes from the pipeline to the state block
	typedef struct packed {
		logic advance;
		logic frame_end;
	} state_ctl_t;

endpackage

// ===== rtl/core/bam_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_in_if
// valid/ready channel carrying pixel and frame-end commands
// ----------------------------------------------------------------------------
interface bam_in_if
	import bam_pkg::*;
;
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/bam_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_out_if
// valid/ready channel carrying serial data bits, latch and frame number
// ----------------------------------------------------------------------------
interface bam_out_if
	import bam_pkg::*;
;
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/bam_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_state
// modulation tables, phase step and frame counter
// ----------------------------------------------------------------------------
module bam_state
	import bam_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  state_ctl_t ctl,
	output byte_t      taps,
	output count_t     frame_count
);

	byte_t  tab_q [NumTables][TableDepth];
	step_t  step_q;
	count_t count_q;
	logic   cur_sel;

	assign cur_sel = step_q[3];

	// bit 3 of every byte of the current table
	always_comb begin
		for (int i = 0; i < TableDepth; i++) begin
			taps[i] = tab_q[cur_sel][i][TapBit];
		end
	end

	assign frame_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q   <= TableInit;
			step_q  <= StepReset;
			count_q <= '0;
		end else if (ctl.advance && ctl.frame_end) begin
			// rotate each byte of the current table left by one bit
			for (int i = 0; i < TableDepth; i++) begin
				tab_q[cur_sel][i] <= {tab_q[cur_sel][i][6:0], tab_q[cur_sel][i][7]};
			end
			step_q  <= step_q + 4'd1;
			count_q <= count_q + 32'd1;
		end
	end

endmodule

// ===== rtl/core/bam_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_lookup
// maps one command to its serial bits, latch and frame number
// ----------------------------------------------------------------------------
module bam_lookup
	import bam_pkg::*;
(
	input  in_item_t  item,
	input  byte_t     taps,
	input  count_t    frame_count,
	output out_item_t res
);

	idx_t red_idx;
	idx_t green_idx;
	idx_t blue_idx;

	assign red_idx   = item.pixel_color[2:0];
	assign green_idx = item.pixel_color[5:3];
	assign blue_idx  = {item.pixel_color[7:6], 1'b0};

	always_comb begin
		res = '0;
		case (item.command)
			CmdFrameEnd: begin
				res.latch_pulse  = 1'b1;
				res.frame_number = frame_count + 32'd1;
			end
			default: begin
				res.blue_bit     = taps[blue_idx];
				res.green_bit    = taps[green_idx];
				res.red_bit      = taps[red_idx];
				res.frame_number = frame_count;
			end
		endcase
	end

endmodule

// ===== rtl/core/led_matrix_modulation_driver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_modulation_driver
// bit angle modulation lookup for an rgb led matrix shift chain
// ----------------------------------------------------------------------------
// channel  direction  content
// pixel    sink       command, pixel_color
// result   source     blue_bit, green_bit, red_bit, latch_pulse, frame_number
//
// one command per cycle sustained while the result side is ready
// stages: input register, table lookup, result register
// tables, step and frame counter update as a frame end leaves the input register
// a stalled result holds both stages; reset restores the constant tables
// ----------------------------------------------------------------------------
module led_matrix_modulation_driver
	import bam_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	bam_in_if.sink       pixel,
	bam_out_if.source    result
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic       res_valid_q;
	out_item_t  res_q;
	logic       advance;
	state_ctl_t ctl;
	byte_t      taps;
	count_t     frame_count;
	out_item_t  res_d;

	assign advance     = valid_s1 && (!res_valid_q || result.ready);
	assign pixel.ready = !valid_s1 || advance;

	assign ctl.advance   = advance;
	assign ctl.frame_end = (item_s1.command == CmdFrameEnd);

	bam_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.taps        (taps),
		.frame_count (frame_count)
	);

	bam_lookup u_lookup (
		.item        (item_s1),
		.taps        (taps),
		.frame_count (frame_count),
		.res         (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.valid && pixel.ready) begin
			item_s1 <= pixel.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

endmodule

// ===== rtl/core/bam_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_checker
// port-level checks of the led matrix modulation driver
// ----------------------------------------------------------------------------
`include "led_matrix_modulation_driver_assert.svh"

module bam_checker
	import bam_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_ready,
	input out_item_t res_payload
);

	count_t last_q;
	logic   res_xfer;

	assign res_xfer = res_valid && res_ready;

	// frame number of the last result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (res_xfer) begin
			last_q <= res_payload.frame_number;
		end
	end

	`BAM_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_payload))
	`BAM_ASSERT_IMPLY(a_latch_no_data, clk, arst_n, res_valid && res_payload.latch_pulse, !res_payload.blue_bit && !res_payload.green_bit && !res_payload.red_bit)
	`BAM_ASSERT_IMPLY(a_pixel_count, clk, arst_n, res_xfer && !res_payload.latch_pulse, res_payload.frame_number == last_q)
	`BAM_ASSERT_IMPLY(a_frame_count, clk, arst_n, res_xfer && res_payload.latch_pulse, res_payload.frame_number == last_q + 32'd1)

endmodule

bind led_matrix_modulation_driver bam_checker u_bam_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_payload (result.payload)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the led matrix modulation driver
// ----------------------------------------------------------------------------
// pixel and frame-end commands go in over the valid/ready channel, and a
// scoreboard keeps its own copy of the modulation tables, phase step and frame
// count. It predicts every result and compares the results in order, field by
// field. A directed sweep of every table index comes first, then random frames
// with noise under three pacing phases, a long result stall and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
	import bam_pkg::*;

	localparam int unsigned ResetCycles  = 5;
	localparam int unsigned RandomItems  = 500;
	localparam int unsigned HoldCycles   = 64;
	localparam int unsigned DrainCycles  = 10;
	localparam int unsigned IdleLimit    = 2000;

	class bam_scoreboard;
		byte_t       tables [NumTables][TableDepth];
		step_t       step;
		count_t      frames;
		out_item_t   awaited_outputs[$];
		int unsigned errors;
		int unsigned pixels;
		int unsigned frame_ends;
		int unsigned compared;

		function new();
			for (int t = 0; t < NumTables; t++)
				for (int i = 0; i < TableDepth; i++)
					tables[t][i] = TableInit[t][i];
			step = StepReset;
			frames = '0;
			errors = 0;
			pixels = 0;
			frame_ends = 0;
			compared = 0;
		endfunction

		// data bits of a pixel, or rotate the current table at frame end
		function out_item_t shift_out(in_item_t cmd);
			out_item_t res;
			logic      cur;
			idx_t      blue_idx;
			res = '0;
			cur = step[3];
			if (cmd.command == CmdPixel) begin
				blue_idx = {cmd.pixel_color[7:6], 1'b0};
				res.blue_bit  = tables[cur][blue_idx][TapBit];
				res.green_bit = tables[cur][cmd.pixel_color[5:3]][TapBit];
				res.red_bit   = tables[cur][cmd.pixel_color[2:0]][TapBit];
				pixels++;
			end else begin
				for (int i = 0; i < TableDepth; i++)
					tables[cur][i] = {tables[cur][i][6:0], tables[cur][i][7]};
				step = step + 4'd1;
				frames = frames + 32'd1;
				res.latch_pulse = 1'b1;
				frame_ends++;
			end
			res.frame_number = frames;
			return res;
		endfunction

		function void note_command(in_item_t cmd);
			awaited_outputs.push_back(shift_out(cmd));
		endfunction

		function void compare_field(string name, longint unsigned exp, longint unsigned got);
			if (exp != got) begin
				$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
				errors++;
			end
		endfunction

		function void check_output(out_item_t got);
			out_item_t exp;
			if (awaited_outputs.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %p", $time, got);
				errors++;
				return;
			end
			exp = awaited_outputs.pop_front();
			compared++;
			compare_field("blue_bit", exp.blue_bit, got.blue_bit);
			compare_field("green_bit", exp.green_bit, got.green_bit);
			compare_field("red_bit", exp.red_bit, got.red_bit);
			compare_field("latch_pulse", exp.latch_pulse, got.latch_pulse);
			compare_field("frame_number", exp.frame_number, got.frame_number);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bam_in_if  pixel_if ();
	bam_out_if result_if ();

	led_matrix_modulation_driver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_if),
		.result (result_if)
	);

	bam_scoreboard sb = new();

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          hold_request;
	int unsigned idle_cycles;

	always #10 clk = ~clk;

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_if.valid && pixel_if.ready)
				sb.note_command(pixel_if.payload);
			if (result_if.valid && result_if.ready)
				sb.check_output(result_if.payload);
			if ((pixel_if.valid && pixel_if.ready) || (result_if.valid && result_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("%0t ns: no transfer for %0d cycles", $time, IdleLimit);
				$display("FAIL");
				$finish;
			end
		end
	end

	// result side: random back-pressure, plus one long hold when asked
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = HoldCycles;
				hold_request = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// valid stays high from one transfer to the next unless a gap is drawn
	task automatic send_command(input in_item_t cmd);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_if.valid <= 1'b0;
			@(posedge clk);
		end
		pixel_if.valid <= 1'b1;
		pixel_if.payload <= cmd;
		do @(posedge clk); while (!pixel_if.ready);
	endtask

	task automatic send_pixel(input byte_t color);
		in_item_t cmd;
		cmd.command = CmdPixel;
		cmd.pixel_color = color;
		send_command(cmd);
	endtask

	task automatic send_frame_end(input byte_t color);
		in_item_t cmd;
		cmd.command = CmdFrameEnd;
		cmd.pixel_color = color;
		send_command(cmd);
	endtask

	// pixels that hit every table index on red and green, every even one on blue, 00 and ff included
	task automatic sweep_indices();
		idx_t idx;
		for (int i = 0; i < TableDepth; i++) begin
			idx = idx_t'(i);
			send_pixel({idx[2:1], idx, idx});
		end
	endtask

	task automatic wait_drained();
		pixel_if.valid <= 1'b0;
		do @(posedge clk); while (sb.awaited_outputs.size() != 0);
	endtask

	// mostly whole frames of random pixels, some loose commands of either kind
	task automatic send_random(input int unsigned count);
		int unsigned sent;
		int unsigned len;
		in_item_t    cmd;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 15) begin
				cmd.command = 1'($urandom_range(1));
				cmd.pixel_color = byte_t'($urandom_range(255));
				send_command(cmd);
				sent++;
			end else begin
				len = $urandom_range(12);
				repeat (len) send_pixel(byte_t'($urandom_range(255)));
				send_frame_end(byte_t'($urandom_range(255)));
				sent += len + 1;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pixel_if.valid = 1'b0;
		pixel_if.payload = '0;
		hold_request = 1'b0;
		idle_cycles = 0;
		send_idle_pct = 21;
		recv_idle_pct = 73;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sweep_indices();
		send_frame_end(8'hFF);
		send_pixel(8'hA5);
		send_pixel(8'h5A);
		// four more frame ends reach step 9, where the second table is current
		repeat (4) send_frame_end(byte_t'($urandom_range(255)));
		sweep_indices();
		wait_drained();

		send_random(RandomItems / 3);
		send_idle_pct = 73;
		recv_idle_pct = 21;
		send_random(RandomItems / 3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		send_random(RandomItems - 2 * (RandomItems / 3));

		wait_drained();
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d pixels and %0d frame ends under three pacing phases and one long stall",
			sb.pixels, sb.frame_ends);
		$display("%0d results compared, final frame count %0d, phase step %0d",
			sb.compared, sb.frames, sb.step);
		if (sb.errors == 0 && sb.awaited_outputs.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
